/* rtl/core/ovn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ovn_pkg;

    // Seed grid geometry
    localparam int GRID_LOG2 = 6;
    localparam int COORD_W   = GRID_LOG2;
    localparam int CELL_W    = 2 * GRID_LOG2;
    localparam int CELL_CNT  = 1 << CELL_W;
    localparam int SEED_W    = 16;
    localparam int OCT_W     = 3;
    localparam int BIAS_W    = 16;

    // Weights are Q25.16, saturated at 2^40
    localparam int WEIGHT_W  = 41;
    localparam int TOTAL_W   = 43;
    localparam int SUM_W     = 59;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {1'b1, {(WEIGHT_W-1){1'b0}}};

    // Shared restoring divider
    localparam int DIV_REM_W = TOTAL_W;
    localparam int DIV_LOW_W = WEIGHT_W;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_WEIGHT = DIV_CNT_W'(WEIGHT_W);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_FINAL  = DIV_CNT_W'(SEED_W);

    // APB register indexes
    localparam logic REG_OCTAVE_COUNT = 1'b0;
    localparam logic REG_OCTAVE_BIAS  = 1'b1;

    // Input op codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
        logic [DIV_REM_W-1:0] rem;
        logic [DIV_LOW_W-1:0] low;
        logic [DIV_REM_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_LOW_W-1:0] quot;
    } t_div_rsp;

    // First half of (1 - cos(pi*k/64)) / 2 in Q0.16
    localparam logic [15:0] BLEND_HALF [0:32] = '{
        16'd0,     16'd39,    16'd158,   16'd355,   16'd630,   16'd982,   16'd1411,  16'd1915,
        16'd2494,  16'd3146,  16'd3869,  16'd4662,  16'd5522,  16'd6448,  16'd7438,  16'd8489,
        16'd9598,  16'd10762, 16'd11980, 16'd13248, 16'd14563, 16'd15922, 16'd17321, 16'd18758,
        16'd20228, 16'd21729, 16'd23256, 16'd24806, 16'd26375, 16'd27960, 16'd29556, 16'd31160,
        16'd32768
    };

    // Blend curve at position k/64; the curve is odd-symmetric about the midpoint
    function automatic logic [15:0] blend_weight(input logic [5:0] k);
        logic [5:0] m;
        m = 6'(7'd64 - {1'b0, k});
        if (k <= 6'd32) begin
            return BLEND_HALF[k];
        end
        return 16'(17'h10000 - {1'b0, BLEND_HALF[m]});
    endfunction

endpackage

`default_nettype wire

/* rtl/core/octave_value_noise_2d.sv */
// Seed write: accepted while idle, no result; the next item may follow at once.
// Query: each further octave's weight comes from the 41-step weight division in the
// shared divider unless it saturates; the final normalization uses the same divider.
// One 18x42 multiplier is shared.
// Synchronous active-low reset clears control and config (count 1, bias 2.0);
// seed memory is not cleared and must be written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module octave_value_noise_2d (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_op,
    input  wire logic [ovn_pkg::CELL_W-1:0]    i_cell_index,
    input  wire logic [ovn_pkg::SEED_W-1:0]    i_seed_value,
    input  wire logic [ovn_pkg::COORD_W-1:0]   i_point_x,
    input  wire logic [ovn_pkg::COORD_W-1:0]   i_point_y,
    // output channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [ovn_pkg::SEED_W-1:0]         o_noise_value,
    // APB config port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import ovn_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_MIX   = 7'b0000100,
        S_WDIV  = 7'b0001000,
        S_FINIT = 7'b0010000,
        S_FDIV  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    localparam logic [COORD_W:0] PITCH0 = (COORD_W+1)'(1 << COORD_W);

    // control
    t_state              r_state, n_state;
    logic [2:0]          r_step,  n_step;
    logic [OCT_W-1:0]    r_oct,   n_oct;
    logic                r_out_valid;
    logic [OCT_W-1:0]    r_octave_count;
    logic [BIAS_W-1:0]   r_octave_bias;

    // datapath
    logic [SEED_W-1:0]   mem [0:CELL_CNT-1];
    logic [SEED_W-1:0]   r_rdata;
    logic [COORD_W-1:0]  r_px, r_py;
    logic [OCT_W-1:0]    r_last_oct;
    logic [BIAS_W-1:0]   r_bias;
    logic [15:0]         r_bx, r_by;
    logic [SEED_W-1:0]   r_s0, r_s1, r_s2, r_s3;
    logic [SEED_W-1:0]   r_top, r_bot, r_sample;
    logic signed [59:0]  r_prod;
    logic [WEIGHT_W-1:0] r_weight;
    logic [SUM_W-1:0]    r_sum;
    logic [TOTAL_W-1:0]  r_total;
    logic [SEED_W-1:0]   r_noise;

    logic                in_acc, out_acc, out_free, cfg_wr;
    logic [COORD_W-1:0]  lo_mask, x1, x2, y1, y2;
    logic [COORD_W:0]    pitch;
    logic [CELL_W-1:0]   rd_addr;
    logic signed [17:0]  mul_a;
    logic signed [41:0]  mul_b;
    logic signed [35:0]  rnd_sum;
    logic [SEED_W-1:0]   mix_base;
    logic [17:0]         mix_res;
    logic                last_oct, w_sat;
    logic [SUM_W-1:0]    fin_num;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_noise_value = r_noise;

    // Config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_OCTAVE_COUNT: prdata = {{(32-OCT_W){1'b0}}, r_octave_count};
            REG_OCTAVE_BIAS:  prdata = {{(32-BIAS_W){1'b0}}, r_octave_bias};
            default:          prdata = '0;
        endcase
    end

    // Lattice around the point for the current octave
    assign pitch   = PITCH0 >> r_oct;
    assign lo_mask = COORD_W'(pitch - 1'b1);
    assign x1      = r_px & ~lo_mask;
    assign y1      = r_py & ~lo_mask;
    assign x2      = COORD_W'({1'b0, x1} + pitch);
    assign y2      = COORD_W'({1'b0, y1} + pitch);

    always_comb begin
        unique case (r_step)
            3'd0:    rd_addr = {y1, x1};
            3'd1:    rd_addr = {y1, x2};
            3'd2:    rd_addr = {y2, x1};
            default: rd_addr = {y2, x2};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_op == OP_WRITE)) begin
            mem[i_cell_index] <= i_seed_value;
        end
        r_rdata <= mem[rd_addr];
    end

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_step)
            3'd0: begin
                mul_a = $signed({2'b00, r_s1}) - $signed({2'b00, r_s0});
                mul_b = $signed({26'd0, r_bx});
            end
            3'd1: begin
                mul_a = $signed({2'b00, r_s3}) - $signed({2'b00, r_s2});
                mul_b = $signed({26'd0, r_bx});
            end
            3'd3: begin
                mul_a = $signed({2'b00, r_bot}) - $signed({2'b00, r_top});
                mul_b = $signed({26'd0, r_by});
            end
            3'd5: begin
                mul_a = $signed({2'b00, r_sample});
                mul_b = $signed({1'b0, r_weight});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        unique case (r_step)
            3'd1:    mix_base = r_s0;
            3'd2:    mix_base = r_s2;
            default: mix_base = r_top;
        endcase
    end

    // a + round((b - a) * w / 2^16)
    assign rnd_sum = $signed(r_prod[35:0]) + 36'sd32768;
    assign mix_res = {2'b00, mix_base} + rnd_sum[33:16];

    assign last_oct = (r_oct == r_last_oct);
    assign w_sat    = ({{(BIAS_W-12){1'b0}}, r_weight[WEIGHT_W-1:WEIGHT_W-12]} >= r_bias);
    assign fin_num  = r_sum + {{(SUM_W-TOTAL_W+1){1'b0}}, r_total[TOTAL_W-1:1]};

    always_comb begin
        div_req = '0;
        if (r_state == S_FINIT) begin
            div_req.start   = 1'b1;
            div_req.steps   = DIV_STEPS_FINAL;
            div_req.rem     = fin_num[SUM_W-1:SEED_W];
            div_req.low     = {fin_num[SEED_W-1:0], {(DIV_LOW_W-SEED_W){1'b0}}};
            div_req.divisor = r_total;
        end else begin
            div_req.start   = (r_state == S_MIX) && (r_step == 3'd6) && !last_oct && !w_sat;
            div_req.steps   = DIV_STEPS_WEIGHT;
            div_req.rem     = {{(DIV_REM_W-12){1'b0}}, r_weight[WEIGHT_W-1:WEIGHT_W-12]};
            div_req.low     = {r_weight[WEIGHT_W-13:0], 12'd0};
            div_req.divisor = {{(DIV_REM_W-BIAS_W){1'b0}}, r_bias};
        end
    end

    ovn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_oct   = r_oct;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_op == OP_QUERY)) begin
                    n_state = S_RD;
                    n_step  = '0;
                    n_oct   = '0;
                end
            end
            S_RD: begin
                if (r_step == 3'd4) begin
                    n_state = S_MIX;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_MIX: begin
                if (r_step == 3'd6) begin
                    n_step = '0;
                    if (last_oct) begin
                        n_state = S_FINIT;
                    end else if (w_sat) begin
                        n_state = S_RD;
                        n_oct   = r_oct + 1'b1;
                    end else begin
                        n_state = S_WDIV;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_WDIV: begin
                if (div_rsp.done) begin
                    n_state = S_RD;
                    n_oct   = r_oct + 1'b1;
                end
            end
            S_FINIT: n_state = S_FDIV;
            S_FDIV: begin
                if (div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_step         <= '0;
            r_oct          <= '0;
            r_out_valid    <= 1'b0;
            r_octave_count <= OCT_W'(1);
            r_octave_bias  <= BIAS_W'(8192);
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_oct   <= n_oct;
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_OCTAVE_COUNT: r_octave_count <= pwdata[OCT_W-1:0];
                    REG_OCTAVE_BIAS:  r_octave_bias  <= pwdata[BIAS_W-1:0];
                    default:          r_octave_count <= r_octave_count;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_op == OP_QUERY)) begin
            r_px       <= i_point_x;
            r_py       <= i_point_y;
            r_last_oct <= (r_octave_count == '0) ? '0 : r_octave_count - 1'b1;
            r_bias     <= (r_octave_bias == '0) ? BIAS_W'(1) : r_octave_bias;
            r_weight   <= WEIGHT_ONE;
            r_sum      <= '0;
            r_total    <= '0;
        end

        if (r_state == S_RD) begin
            unique case (r_step)
                3'd0: begin
                    r_bx <= blend_weight(6'((r_px & lo_mask) << r_oct));
                    r_by <= blend_weight(6'((r_py & lo_mask) << r_oct));
                end
                3'd1:    r_s0 <= r_rdata;
                3'd2:    r_s1 <= r_rdata;
                3'd3:    r_s2 <= r_rdata;
                default: r_s3 <= r_rdata;
            endcase
        end

        if (r_state == S_MIX) begin
            r_prod <= mul_a * mul_b;
            unique case (r_step)
                3'd1: r_top    <= mix_res[SEED_W-1:0];
                3'd2: r_bot    <= mix_res[SEED_W-1:0];
                3'd4: r_sample <= mix_res[SEED_W-1:0];
                3'd6: begin
                    r_sum   <= r_sum + r_prod[SUM_W-1:0];
                    r_total <= r_total + {{(TOTAL_W-WEIGHT_W){1'b0}}, r_weight};
                    if (!last_oct && w_sat) begin
                        r_weight <= WEIGHT_MAX;
                    end
                end
                default: r_sum <= r_sum;
            endcase
        end

        // clamp the weight at 2^40
        if ((r_state == S_WDIV) && div_rsp.done) begin
            r_weight <= (div_rsp.quot > WEIGHT_MAX) ? WEIGHT_MAX : div_rsp.quot;
        end

        if ((r_state == S_OUT) && out_free) begin
            r_noise <= div_rsp.quot[SEED_W-1:0];
        end
    end

    // Checks
    a_div_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WDIV) || (r_state == S_FDIV)) |-> div_rsp.busy)
        else $error("divider idle while the sequencer waits on it");

    a_oct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD) || (r_state == S_MIX)) |-> (r_oct <= r_last_oct))
        else $error("octave index past the last octave");

    a_total_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINIT) |-> (r_total >= TOTAL_W'(65536)))
        else $error("weight total below one at final division");

    a_weight_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD) || (r_state == S_MIX)) |-> (r_weight <= WEIGHT_MAX))
        else $error("weight above saturation limit");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && out_free) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("finished query did not reach the output register");

endmodule

`default_nettype wire

/* rtl/core/ovn_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module ovn_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  ovn_pkg::t_div_req      i_req,
    output ovn_pkg::t_div_rsp      o_rsp
);
    import ovn_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_REM_W-1:0] r_rem;
    logic [DIV_LOW_W-1:0] r_low;
    logic [DIV_REM_W-1:0] r_dvs;

    logic [DIV_REM_W:0]   cat;
    logic [DIV_REM_W+1:0] diff;
    logic                 qbit;

    assign cat  = {r_rem, r_low[DIV_LOW_W-1]};
    assign diff = {1'b0, cat} - {2'b00, r_dvs};
    assign qbit = !diff[DIV_REM_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.steps;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // One quotient bit per cycle; quotient shifts into the low dividend bits
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_low <= i_req.low;
            r_dvs <= i_req.divisor;
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= qbit ? diff[DIV_REM_W-1:0] : cat[DIV_REM_W-1:0];
            r_low <= {r_low[DIV_LOW_W-2:0], qbit};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_busy && (r_cnt == '0);
    assign o_rsp.quot = r_low;

endmodule

`default_nettype wire

/* tb/sv/noise_checker.sv */
`timescale 1ns / 1ps

module noise_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          in_op,
    input  logic [ovn_pkg::CELL_W-1:0]    in_cell,
    input  logic [ovn_pkg::SEED_W-1:0]    in_seed,
    input  logic [ovn_pkg::COORD_W-1:0]   in_x,
    input  logic [ovn_pkg::COORD_W-1:0]   in_y,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [ovn_pkg::SEED_W-1:0]    out_noise,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    input  logic [31:0]                   prdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            pending_count,
    output int                            checked_count
);

    localparam int SIDE = 1 << ovn_pkg::COORD_W;
    localparam longint unsigned WEIGHT_CAP = 64'd1 << 40;

    // Rising half of (1 - cos(pi*k/64)) / 2, Q0.16
    localparam logic [15:0] RAMP_HALF [0:32] = '{
        16'd0,     16'd39,    16'd158,   16'd355,   16'd630,   16'd982,   16'd1411,  16'd1915,
        16'd2494,  16'd3146,  16'd3869,  16'd4662,  16'd5522,  16'd6448,  16'd7438,  16'd8489,
        16'd9598,  16'd10762, 16'd11980, 16'd13248, 16'd14563, 16'd15922, 16'd17321, 16'd18758,
        16'd20228, 16'd21729, 16'd23256, 16'd24806, 16'd26375, 16'd27960, 16'd29556, 16'd31160,
        16'd32768
    };

    logic [ovn_pkg::SEED_W-1:0] seeds [0:ovn_pkg::CELL_CNT-1];
    logic [ovn_pkg::OCT_W-1:0]  octaves;
    logic [ovn_pkg::BIAS_W-1:0] bias;
    logic [ovn_pkg::SEED_W-1:0] expected_noise [$];

    initial begin
        octaves       = 3'd1;
        bias          = 16'd8192;
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
    end

    function automatic int unsigned ramp_entry(input int unsigned k);
        if (k > 64) k = 64;
        if (k <= 32) return RAMP_HALF[k];
        return 65536 - RAMP_HALF[64 - k];
    endfunction

    // Top 6 bits pick the ROM step, low 10 bits interpolate (floored)
    function automatic int unsigned cosine_ramp(input int unsigned t);
        int unsigned lo, hi;
        lo = ramp_entry((t >> 10) & 63);
        hi = ramp_entry(((t >> 10) & 63) + 1);
        return lo + (((hi - lo) * (t & 1023)) >> 10);
    endfunction

    function automatic int unsigned lerp_seeds(input int unsigned a, input int unsigned b,
                                               input int unsigned w);
        longint unsigned acc;
        acc = 64'(a) * 64'(65536 - w) + 64'(b) * 64'(w) + 64'd32768;
        return int'(acc >> 16);
    endfunction

    function automatic logic [ovn_pkg::SEED_W-1:0] predict_noise(input int unsigned px,
                                                                 input int unsigned py);
        int unsigned n, pitch, x1, y1, x2, y2, bx, by, upper, lower, octave_sample, divisor;
        longint unsigned weight, total, acc;
        n = (octaves == 0) ? 1 : octaves;
        while (n > 1 && (SIDE >> (n - 1)) == 0) n--;
        divisor = (bias == 0) ? 1 : bias;
        weight = 65536;
        total = 0;
        acc = 0;
        for (int unsigned o = 0; o < n; o++) begin
            pitch = SIDE >> o;
            x1 = (px / pitch) * pitch;
            y1 = (py / pitch) * pitch;
            x2 = (x1 + pitch) % SIDE;
            y2 = (y1 + pitch) % SIDE;
            bx = cosine_ramp(((px - x1) << 16) / pitch);
            by = cosine_ramp(((py - y1) << 16) / pitch);
            upper = lerp_seeds(seeds[y1 * SIDE + x1], seeds[y1 * SIDE + x2], bx);
            lower = lerp_seeds(seeds[y2 * SIDE + x1], seeds[y2 * SIDE + x2], bx);
            octave_sample = lerp_seeds(upper, lower, by);
            total += weight;
            acc += 64'(octave_sample) * weight;
            weight = (weight << 12) / divisor;
            if (weight > WEIGHT_CAP) weight = WEIGHT_CAP;
        end
        return 16'((acc + total / 2) / total);
    endfunction

    always @(posedge clk) begin
        logic [ovn_pkg::SEED_W-1:0] want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_noise.size() == 0) begin
                    $error("noise_value %0d arrived with no query outstanding", out_noise);
                    fail_count++;
                end else begin
                    want = expected_noise.pop_front();
                    checked_count++;
                    if (out_noise !== want) begin
                        $error("noise_value mismatch: expected %0d, actual %0d", want, out_noise);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                if (in_op == ovn_pkg::OP_QUERY)
                    expected_noise.push_back(predict_noise(in_x, in_y));
                else
                    seeds[in_cell] = in_seed;
            end
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == {ovn_pkg::REG_OCTAVE_COUNT, 2'b00})
                        octaves = pwdata[ovn_pkg::OCT_W-1:0];
                    else if (paddr == {ovn_pkg::REG_OCTAVE_BIAS, 2'b00})
                        bias = pwdata[ovn_pkg::BIAS_W-1:0];
                end else if (paddr == {ovn_pkg::REG_OCTAVE_COUNT, 2'b00}) begin
                    if (prdata[ovn_pkg::OCT_W-1:0] !== octaves) begin
                        $error("octave_count mismatch: expected %0d, actual %0d",
                               octaves, prdata[ovn_pkg::OCT_W-1:0]);
                        fail_count++;
                    end
                end else if (paddr == {ovn_pkg::REG_OCTAVE_BIAS, 2'b00}) begin
                    if (prdata[ovn_pkg::BIAS_W-1:0] !== bias) begin
                        $error("octave_bias mismatch: expected %0d, actual %0d",
                               bias, prdata[ovn_pkg::BIAS_W-1:0]);
                        fail_count++;
                    end
                end
            end
            pending_count = expected_noise.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import ovn_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int ITEM_GOAL   = 1800;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 9;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_op;
    logic [CELL_W-1:0]   i_cell_index;
    logic [SEED_W-1:0]   i_seed_value;
    logic [COORD_W-1:0]  i_point_x;
    logic [COORD_W-1:0]  i_point_y;
    logic                o_valid;
    logic                i_stall;
    logic [SEED_W-1:0]   o_noise_value;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int          fail_count, pending_count, checked_count;
    int          items_sent, queries_sent, configs_applied;
    int unsigned octaves_in_use;
    logic        calm;
    bit          cell_written [CELL_CNT];
    int unsigned phase_octaves [0:PHASES-1];
    int unsigned phase_bias [0:PHASES-1];

    always #5 i_clk = ~i_clk;

    octave_value_noise_2d dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_cell_index  (i_cell_index),
        .i_seed_value  (i_seed_value),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_noise_value (o_noise_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    noise_checker noise_check (
        .clk           (i_clk),
        .rst_n         (i_rst_n),
        .in_valid      (i_valid),
        .in_stall      (o_stall),
        .in_op         (i_op),
        .in_cell       (i_cell_index),
        .in_seed       (i_seed_value),
        .in_x          (i_point_x),
        .in_y          (i_point_y),
        .out_valid     (o_valid),
        .out_stall     (i_stall),
        .out_noise     (o_noise_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    task automatic send_item(input logic op, input logic [CELL_W-1:0] entry,
                             input logic [SEED_W-1:0] seed,
                             input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
        while (!calm && $urandom_range(0, 99) < 15) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_cell_index <= entry;
        i_seed_value <= seed;
        i_point_x    <= px;
        i_point_y    <= py;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        if (op == OP_QUERY) queries_sent++;
        else cell_written[entry] = 1'b1;
    endtask

    task automatic send_write(input logic [CELL_W-1:0] entry, input logic [SEED_W-1:0] seed);
        send_item(OP_WRITE, entry, seed, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // Seed every lattice corner the query will touch before it goes out
    task automatic send_query(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
        int unsigned pitch, x1, y1, x2, y2;
        int unsigned corner [4];
        for (int unsigned o = 0; o < octaves_in_use; o++) begin
            pitch = 64 >> o;
            x1 = (px / pitch) * pitch;
            y1 = (py / pitch) * pitch;
            x2 = (x1 + pitch) % 64;
            y2 = (y1 + pitch) % 64;
            corner[0] = y1 * 64 + x1;
            corner[1] = y1 * 64 + x2;
            corner[2] = y2 * 64 + x1;
            corner[3] = y2 * 64 + x2;
            foreach (corner[k])
                if (!cell_written[corner[k]]) send_write(CELL_W'(corner[k]), SEED_W'($urandom));
        end
        send_item(OP_QUERY, CELL_W'($urandom), SEED_W'($urandom), px, py);
    endtask

    task automatic wait_drained();
        repeat (2) @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input int unsigned count, input int unsigned bias_value);
        i_valid <= 1'b0;
        wait_drained();
        // let a trailing seed write retire
        repeat (20) @(posedge i_clk);
        apb_access(1'b1, REG_OCTAVE_COUNT, 32'(count));
        apb_access(1'b1, REG_OCTAVE_BIAS, 32'(bias_value));
        apb_access(1'b0, REG_OCTAVE_COUNT, 32'd0);
        apb_access(1'b0, REG_OCTAVE_BIAS, 32'd0);
        octaves_in_use = (count == 0) ? 1 : count;
        configs_applied++;
    endtask

    task automatic random_item();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            send_query(COORD_W'($urandom), COORD_W'($urandom));
        else if (pick < 55)
            send_query(COORD_W'($urandom_range(0, 1) * 63), COORD_W'($urandom_range(0, 1) * 63));
        else if (pick < 85)
            send_write(CELL_W'($urandom), SEED_W'($urandom));
        else
            send_write({COORD_W'($urandom_range(0, 1) * 63), COORD_W'($urandom_range(0, 1) * 63)},
                       $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
    endtask

    // Receiver: random stalls, plus one long hold-off to back the block up
    initial begin
        int unsigned results_seen;
        bit held;
        results_seen = 0;
        held = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) results_seen++;
            if (!held && results_seen >= 150) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_stall <= !calm && ($urandom_range(0, 99) < 15);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int goal;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_op            = OP_WRITE;
        i_cell_index    = '0;
        i_seed_value    = '0;
        i_point_x       = '0;
        i_point_y       = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        calm            = 1'b0;
        items_sent      = 0;
        queries_sent    = 0;
        configs_applied = 0;
        octaves_in_use  = 1;
        phase_octaves   = '{7, 7, 3, 0, 4, 2, 5, 6, 1};
        phase_bias      = '{8192, 1, 65535, 0, 0, 4096, 0, 0, 0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: one octave reads only the origin seed
        send_write(CELL_W'(0), 16'hFFFF);
        send_query(6'd63, 6'd63);
        send_query(6'd0, 6'd0);
        send_write(CELL_W'(0), 16'h0000);
        send_query(6'd21, 6'd42);

        // Two octaves: the lattice is the four cells on the half-grid points
        set_config(2, 8192);
        send_write(CELL_W'(32), 16'hFFFF);
        send_write(CELL_W'(2048), 16'hFFFF);
        send_write(CELL_W'(2080), 16'h0000);
        send_write(CELL_W'(CELL_CNT - 1), 16'hFFFF);
        send_query(6'd0, 6'd0);
        send_query(6'd63, 6'd63);
        send_query(6'd63, 6'd0);
        send_query(6'd0, 6'd63);
        send_query(6'd32, 6'd32);
        send_query(6'd31, 6'd31);
        send_query(6'd33, 6'd1);
        send_query(6'd16, 6'd48);

        for (int p = 0; p < PHASES; p++) begin
            set_config(phase_octaves[p],
                       (p == 4 || p >= 6) ? $urandom_range(1, 65535) : phase_bias[p]);
            calm = (p == 5);
            goal = items_sent + (ITEM_GOAL - items_sent) / (PHASES - p);
            while (items_sent < goal) random_item();
        end
        calm = 1'b0;
        i_valid <= 1'b0;
        wait_drained();
        repeat (60) @(posedge i_clk);

        $display("Covered %0d transactions: %0d noise queries, %0d seed writes, %0d results checked.",
                 items_sent, queries_sent, items_sent - queries_sent, checked_count);
        $display("Octave settings applied: %0d (counts 0 to 7, bias 0, 1, 1.0, 2.0, max, random).",
                 configs_applied);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/ovn_pkg.sv
rtl/core/ovn_div.sv
rtl/core/octave_value_noise_2d.sv
tb/sv/noise_checker.sv
tb/sv/testbench.sv
